### rtl/cde_pkg.sv
// cde_pkg: shared opcodes, status codes and cell control types for the deque engine.
// No dependencies.
package cde_pkg;

	localparam int unsigned WORD_W = 32;

	localparam logic [2:0] OPC_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OPC_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OPC_POP_FRONT  = 3'd2;
	localparam logic [2:0] OPC_POP_BACK   = 3'd3;
	localparam logic [2:0] OPC_LIST       = 3'd4;

	localparam logic [2:0] STS_INSERTED = 3'd0;
	localparam logic [2:0] STS_REMOVED  = 3'd1;
	localparam logic [2:0] STS_EMPTY    = 3'd2;
	localparam logic [2:0] STS_FULL     = 3'd3;
	localparam logic [2:0] STS_LISTED   = 3'd4;

	typedef enum logic [2:0] {
		CELL_HOLD       = 3'd0,
		CELL_PUSH_FRONT = 3'd1,
		CELL_PUSH_BACK  = 3'd2,
		CELL_POP_FRONT  = 3'd3,
		CELL_POP_BACK   = 3'd4,
		CELL_ROTATE     = 3'd5
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [WORD_W-1:0]   value;
	} cell_ctrl_t;

endpackage

### rtl/cde_cell.sv
// cde_cell: one slot of the deque chain; holds a word and an occupied flag.
// Depends on cde_pkg.
module cde_cell
	import cde_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic              left_valid,
	input  logic [WORD_W-1:0] left_data,
	input  logic              right_valid,
	input  logic [WORD_W-1:0] right_data,
	input  logic [WORD_W-1:0] head_data,
	output logic              valid,
	output logic [WORD_W-1:0] data,
	output logic [WORD_W-1:0] tail_data
);

	logic              valid_q;
	logic [WORD_W-1:0] data_q;
	logic              is_tail;
	logic              is_slot;

	assign is_tail   = valid_q && !right_valid;
	assign is_slot   = !valid_q && left_valid;
	assign valid     = valid_q;
	assign data      = data_q;
	assign tail_data = is_tail ? data_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctrl.op)
				CELL_PUSH_FRONT: valid_q <= left_valid;
				CELL_PUSH_BACK:  if (is_slot) valid_q <= 1'b1;
				CELL_POP_FRONT:  valid_q <= right_valid;
				CELL_POP_BACK:   if (is_tail) valid_q <= 1'b0;
				default:         valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_PUSH_FRONT: data_q <= left_data;
			CELL_PUSH_BACK:  if (is_slot) data_q <= ctrl.value;
			CELL_POP_FRONT:  data_q <= right_data;
			CELL_ROTATE: begin
				if (is_tail) data_q <= head_data;
				else if (valid_q) data_q <= right_data;
			end
			default:         data_q <= data_q;
		endcase
	end

endmodule

### rtl/circular_deque_engine_top.sv
// circular_deque_engine_top: double-ended queue of signed words built as a chain of cells.
// Depends on cde_pkg and cde_cell.
//
// The queue is a row of DEPTH cells with the front word always in cell 0. Push front and pop
// front shift the whole row by one cell, push back fills the first free cell, pop back empties
// the last occupied one; each gives one result word. A list first starts and then gives each
// stored word in turn as the result stage frees, each step reading cell 0 while the occupied cells
// rotate by one, so the row is back in order after the last word. A push to a full queue and a
// pop or list on an empty one give a single full or empty status. Opcodes 5 to 7 are taken and
// give no result. The result register is a single stage: while idle, a new word is taken whenever
// that stage is empty or being drained, so back pressure on the output stalls the input.
module circular_deque_engine_top
	import cde_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] push_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic signed [31:0] out_value,
	output logic               last
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LIST = 2'b10
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     left_q;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [WORD_W-1:0] value_q;
	logic              last_q;

	cell_ctrl_t        ctrl;
	logic [DEPTH-1:0]  cell_valid;
	logic [WORD_W-1:0] cell_data [DEPTH];
	logic [WORD_W-1:0] cell_tail [DEPTH];
	logic [WORD_W-1:0] tail_or;

	logic              out_free;
	logic              in_fire;
	logic              list_step;
	logic              full;
	logic              empty;
	logic              load;
	logic              list_start;
	logic              cnt_inc;
	logic              cnt_dec;
	logic [2:0]        nxt_status;
	logic [WORD_W-1:0] nxt_value;
	logic              nxt_last;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic              lv;
			logic [WORD_W-1:0] ld;
			logic              rv;
			logic [WORD_W-1:0] rd;
			if (gi == 0) begin : g_first
				assign lv = 1'b1;
				assign ld = ctrl.value;
			end else begin : g_mid_l
				assign lv = cell_valid[gi-1];
				assign ld = cell_data[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign rv = 1'b0;
				assign rd = '0;
			end else begin : g_mid_r
				assign rv = cell_valid[gi+1];
				assign rd = cell_data[gi+1];
			end
			cde_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.left_valid  (lv),
				.left_data   (ld),
				.right_valid (rv),
				.right_data  (rd),
				.head_data   (cell_data[0]),
				.valid       (cell_valid[gi]),
				.data        (cell_data[gi]),
				.tail_data   (cell_tail[gi])
			);
		end
	endgenerate

	always_comb begin
		tail_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_or = tail_or | cell_tail[i];
		end
	end

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign in_fire   = in_valid && in_ready;
	assign list_step = (state_q == S_LIST) && out_free;
	assign full      = (cnt_q == CW'(DEPTH));
	assign empty     = (cnt_q == '0);

	always_comb begin
		ctrl.op    = CELL_HOLD;
		ctrl.value = push_value;
		load       = 1'b0;
		list_start = 1'b0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		nxt_status = STS_EMPTY;
		nxt_value  = '0;
		nxt_last   = 1'b1;
		if (in_fire) begin
			unique case (opcode)
				OPC_PUSH_FRONT, OPC_PUSH_BACK: begin
					load = 1'b1;
					if (full) begin
						nxt_status = STS_FULL;
					end else begin
						nxt_status = STS_INSERTED;
						cnt_inc    = 1'b1;
						ctrl.op    = (opcode == OPC_PUSH_FRONT) ? CELL_PUSH_FRONT
							: CELL_PUSH_BACK;
					end
				end
				OPC_POP_FRONT, OPC_POP_BACK: begin
					load = 1'b1;
					if (!empty) begin
						nxt_status = STS_REMOVED;
						cnt_dec    = 1'b1;
						if (opcode == OPC_POP_FRONT) begin
							nxt_value = cell_data[0];
							ctrl.op   = CELL_POP_FRONT;
						end else begin
							nxt_value = tail_or;
							ctrl.op   = CELL_POP_BACK;
						end
					end
				end
				OPC_LIST: begin
					if (empty) load = 1'b1;
					else list_start = 1'b1;
				end
				default: begin
				end
			endcase
		end else if (list_step) begin
			load       = 1'b1;
			nxt_status = STS_LISTED;
			nxt_value  = cell_data[0];
			nxt_last   = (left_q == CW'(1));
			ctrl.op    = CELL_ROTATE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cnt_inc) cnt_q <= cnt_q + CW'(1);
			else if (cnt_dec) cnt_q <= cnt_q - CW'(1);

			unique case (state_q)
				S_IDLE: begin
					if (list_start) begin
						state_q <= S_LIST;
						left_q  <= cnt_q;
					end
				end
				S_LIST: begin
					if (list_step) begin
						left_q <= left_q - CW'(1);
						if (left_q == CW'(1)) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= nxt_status;
			value_q  <= nxt_value;
			last_q   <= nxt_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_value = $signed(value_q);
	assign last      = last_q;

	a_front_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[0] == (cnt_q != '0))
		else $error("front cell occupancy disagrees with entry count");

	a_back_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[DEPTH-1] == (cnt_q == CW'(DEPTH)))
		else $error("back cell occupancy disagrees with entry count");

	a_list_end: assert property (@(posedge clk) disable iff (!arst_n)
		(list_step && left_q == CW'(1)) |=> (state_q == S_IDLE && out_valid_q && last_q))
		else $error("list did not close with a last word");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above capacity");

endmodule

### dv/tb_circular_deque_engine_top.sv
// tb_circular_deque_engine_top: self-checking testbench for the deque engine top level.
// Depends on cde_pkg and circular_deque_engine_top; a ring-buffer predictor checks every word.
module tb_circular_deque_engine_top;
	import cde_pkg::*;

	localparam int unsigned DEPTH = 16;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam logic [2:0] OPC_LAST_RESERVED = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 60;
	localparam int SETTLE_CYCLES = 20;

	typedef struct {
		logic [2:0]         status;
		logic signed [31:0] value;
		logic               fin;
	} deque_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         opcode = OPC_PUSH_FRONT;
	logic signed [31:0] push_value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic signed [31:0] out_value;
	logic               last;

	// predictor state
	logic signed [31:0] ring_words [DEPTH];
	logic [PTR_W-1:0]   head_pos = '0;
	int unsigned        held_count = 0;
	deque_result_t      pending_results [$];

	int  fail_count = 0;
	int  cycle_count = 0;
	bit  steady = 1'b0;
	bit  fill_bias = 1'b1;
	int  stall_requests = 0;
	int  stall_served = 0;
	int  hold_left = 0;

	circular_deque_engine_top #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_value(out_value),
		.last(last)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("circular_deque_engine_top: mismatch");
			$finish;
		end
	end

	function automatic void note_result(logic [2:0] st, logic signed [31:0] val, logic fin);
		deque_result_t r;
		r.status = st;
		r.value = val;
		r.fin = fin;
		pending_results.push_back(r);
	endfunction

	function automatic void predict_deque_op(logic [2:0] op, logic signed [31:0] val);
		logic [PTR_W-1:0] pos;
		case (op)
			OPC_PUSH_FRONT, OPC_PUSH_BACK: begin
				if (held_count >= DEPTH) begin
					note_result(STS_FULL, '0, 1'b1);
				end else begin
					if (op == OPC_PUSH_FRONT) begin
						head_pos = head_pos - 1'b1;
						ring_words[head_pos] = val;
					end else begin
						pos = head_pos + PTR_W'(held_count);
						ring_words[pos] = val;
					end
					held_count++;
					note_result(STS_INSERTED, '0, 1'b1);
				end
			end
			OPC_POP_FRONT, OPC_POP_BACK: begin
				if (held_count == 0) begin
					note_result(STS_EMPTY, '0, 1'b1);
				end else begin
					if (op == OPC_POP_FRONT) begin
						pos = head_pos;
						head_pos = head_pos + 1'b1;
					end else begin
						pos = head_pos + PTR_W'(held_count - 1);
					end
					held_count--;
					note_result(STS_REMOVED, ring_words[pos], 1'b1);
				end
			end
			OPC_LIST: begin
				if (held_count == 0) begin
					note_result(STS_EMPTY, '0, 1'b1);
				end else begin
					for (int k = 0; k < held_count; k++) begin
						pos = head_pos + PTR_W'(k);
						note_result(STS_LISTED, ring_words[pos], k == held_count - 1);
					end
				end
			end
			default: ;
		endcase
	endfunction

	// result side: random ready, quiet stretches, and a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (stall_requests != stall_served) begin
			stall_served <= stall_requests;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 9);
		end
	end

	always @(posedge clk) begin
		deque_result_t exp_r;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected word: status %0d out_value %0d last %0b",
					status, out_value, last);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, status);
					fail_count++;
				end
				if (out_value !== exp_r.value) begin
					$error("out_value: expected %0d, got %0d", exp_r.value, out_value);
					fail_count++;
				end
				if (last !== exp_r.fin) begin
					$error("last: expected %0b, got %0b", exp_r.fin, last);
					fail_count++;
				end
			end
		end
	end

	// called at a rising edge; returns at the edge that accepted the word, or later after a random pause
	task automatic send_word(input logic [2:0] op, input logic signed [31:0] val);
		in_valid <= 1'b1;
		opcode <= op;
		push_value <= val;
		do @(posedge clk); while (!in_ready);
		predict_deque_op(op, val);
		if (!steady && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_opcode();
		int roll;
		roll = $urandom_range(99);
		if (roll < 3)
			return 3'($urandom_range(OPC_LIST + 1, OPC_LAST_RESERVED));
		if (roll < 10)
			return OPC_LIST;
		if (roll < (fill_bias ? 68 : 35))
			return $urandom_range(1) ? OPC_PUSH_BACK : OPC_PUSH_FRONT;
		return $urandom_range(1) ? OPC_POP_BACK : OPC_POP_FRONT;
	endfunction

	task automatic test_empty_queue();
		send_word(OPC_POP_FRONT, 32'sh7fffffff);
		send_word(OPC_POP_BACK, 32'sh80000000);
		send_word(OPC_LIST, -32'sd1);
	endtask

	task automatic test_reserved_opcodes();
		for (int code = OPC_LIST + 1; code <= OPC_LAST_RESERVED; code++)
			send_word(3'(code), $urandom);
	endtask

	task automatic test_fill_to_full();
		logic signed [31:0] seeds [6];
		seeds = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1, 32'sh55555555, 32'shaaaaaaaa};
		for (int k = 0; k < DEPTH; k++)
			send_word(k[0] ? OPC_PUSH_BACK : OPC_PUSH_FRONT, k < 6 ? seeds[k] : $urandom);
		send_word(OPC_PUSH_FRONT, $urandom);
		send_word(OPC_PUSH_BACK, $urandom);
		send_word(OPC_LIST, $urandom);
		send_word(OPC_POP_FRONT, $urandom);
		send_word(OPC_POP_BACK, $urandom);
	endtask

	task automatic test_output_stall(input int n);
		stall_requests++;
		for (int k = 0; k < n; k++)
			send_word(k % 5 == 4 ? OPC_LIST : pick_opcode(), pick_value());
		drain_results();
	endtask

	task automatic test_random_mix(input int n);
		int flip_at;
		flip_at = $urandom_range(20, 50);
		for (int k = 0; k < n; k++) begin
			if (k == n / 3) steady = 1'b1;
			if (k == n / 3 + 80) steady = 1'b0;
			if (k == flip_at) begin
				fill_bias = !fill_bias;
				flip_at = k + $urandom_range(20, 50);
			end
			send_word(pick_opcode(), pick_value());
		end
		drain_results();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_reserved_opcodes();
		test_fill_to_full();
		drain_results();
		test_output_stall(24);
		test_random_mix(260);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("circular_deque_engine_top: match");
		else
			$display("circular_deque_engine_top: mismatch");
		$finish;
	end

endmodule

### sim.f
rtl/cde_pkg.sv
rtl/cde_cell.sv
rtl/circular_deque_engine_top.sv
dv/tb_circular_deque_engine_top.sv
